// ===== hw/rtl/ssjw_pkg.sv =====
// shared types, constants and the default slot table for the settled slot journal writer
package ssjw_pkg;

   // fixed field widths
   localparam int WORD_W    = 32;
   localparam int HALF_W    = 16;
   localparam int SLOT_ID_W = 8;
   localparam int NUM_KNOBS = 4;
   localparam int PAGE_W    = 3;
   localparam int REC_SLOT_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] RECORD_BYTES = 32'd8;
   localparam logic [WORD_W-1:0] VALUE_OFFSET = 32'd4;

   // reset values of the control registers
   localparam logic [WORD_W-1:0] SECTOR_BASE_RST  = 32'h080E_0000;
   localparam logic [WORD_W-1:0] SECTOR_END_RST   = 32'h0810_0000;
   localparam logic [HALF_W-1:0] RECORD_MAGIC_RST = 16'hA55A;
   localparam logic [HALF_W-1:0] SETTLE_RST       = 16'd64;

   // opcodes
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_POLL   = 2'd1;
   localparam logic [1:0] OP_REPLAY = 2'd2;

   // flash actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ERASE   = 2'd1;
   localparam logic [1:0] ACT_PROGRAM = 2'd2;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_MAGIC = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE       = 2'd3;

   // record save phases
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ID    = 3'b010,
      PH_VALUE = 3'b100
   } phase_type;

   // command broadcast to every slot cell
   typedef struct packed {
      logic                 update;
      logic                 erase;
      logic                 clear;
      logic                 replay;
      logic [PAGE_W-1:0]    page_slot;
      logic [SLOT_ID_W-1:0] clear_slot;
      logic [SLOT_ID_W-1:0] replay_slot;
      logic [WORD_W-1:0]    replay_value;
      logic [HALF_W-1:0]    settle;
   } cmd_type;

   // priority pick handed from cell to cell
   typedef struct packed {
      logic                 found;
      logic [SLOT_ID_W-1:0] slot;
      logic [WORD_W-1:0]    value;
   } pick_type;

   // built-in default words, zero past the table
   function automatic logic [WORD_W-1:0] default_word(input int idx);
      logic [WORD_W-1:0] w;
      case (idx)
         0:  w = 32'h3ED1EB85;
         1:  w = 32'h3E428F5C;
         2:  w = 32'h3F400000;
         3:  w = 32'h3F5C28F6;
         4:  w = 32'h3F63D70A;
         5:  w = 32'h3F570A3D;
         6:  w = 32'h00000000;
         7:  w = 32'h3E800000;
         8:  w = 32'h3F0CCCCD;
         9:  w = 32'h00000000;
         10: w = 32'h3E8F5C29;
         11: w = 32'h3D75C28F;
         12: w = 32'h3F4F5C29;
         13: w = 32'h3F400000;
         14: w = 32'h3F800000;
         15: w = 32'h3F028F5C;
         16: w = 32'h3F800000;
         17: w = 32'h3F800000;
         18: w = 32'h3F800000;
         19: w = 32'h00000000;
         20: w = 32'h3F800000;
         21: w = 32'h00000000;
         22: w = 32'h3F800000;
         23: w = 32'h00000000;
         24: w = 32'h3F5C28F6;
         25: w = 32'h3EBD70A4;
         26: w = 32'h3F266666;
         27: w = 32'h3E6147AE;
         28: w = 32'h3F800000;
         29: w = 32'h3E947AE1;
         30: w = 32'h3E8A3D71;
         31: w = 32'h3EAE147B;
         default: w = 32'h00000000;
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/ssjw_slot_cell.sv =====
// one parameter slot: value word, dirty flag, settle counter and its link in the pick chain
module ssjw_slot_cell #(
   parameter int SLOT_ID        = 0,
   parameter int SLOTS_PER_KNOB = 8,
   parameter bit KNOB_EN        = 1'b1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ssjw_pkg::cmd_type           cmd,
   input  logic [ssjw_pkg::WORD_W-1:0] knob_value,
   input  ssjw_pkg::pick_type          pick_in,
   output ssjw_pkg::pick_type          pick_out,
   output logic                        dirty
);
   import ssjw_pkg::*;

   localparam int PAGE = SLOT_ID % SLOTS_PER_KNOB;
   localparam logic [SLOT_ID_W-1:0] MY_ID   = SLOT_ID_W'(SLOT_ID);
   localparam logic [SLOT_ID_W-1:0] PAGE_ID = SLOT_ID_W'(PAGE);

   logic [WORD_W-1:0] value_ff, value_in;
   logic              dirty_ff, dirty_in;
   logic [HALF_W-1:0] count_ff, count_in;
   logic              settled;
   logic              changed;

   // settled dirty slot, lowest one wins along the chain
   assign settled = dirty_ff && (count_ff >= cmd.settle);

   always_comb begin
      if (pick_in.found) begin
         pick_out = pick_in;
      end else if (settled) begin
         pick_out = '{found: 1'b1, slot: MY_ID, value: value_ff};
      end else begin
         pick_out = pick_in;
      end
   end

   assign dirty = dirty_ff;

   // next slot state
   always_comb begin
      value_in = value_ff;
      dirty_in = dirty_ff;
      count_in = count_ff;
      changed  = KNOB_EN && (SLOT_ID_W'(cmd.page_slot) == PAGE_ID) && (value_ff != knob_value);
      if (cmd.update) begin
         if (changed) begin
            value_in = knob_value;
            dirty_in = 1'b1;
            count_in = (cmd.settle != '0) ? 16'd1 : 16'd0;
         end else if (dirty_ff && (count_ff < cmd.settle)) begin
            count_in = count_ff + 16'd1;
         end
      end
      if (cmd.erase) begin
         dirty_in = 1'b1;
         count_in = cmd.settle;
      end
      if (cmd.clear && (cmd.clear_slot == MY_ID)) begin
         dirty_in = 1'b0;
      end
      if (cmd.replay && (cmd.replay_slot == MY_ID)) begin
         value_in = cmd.replay_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= default_word(SLOT_ID);
         dirty_ff <= 1'b0;
         count_ff <= SETTLE_RST;
      end else begin
         value_ff <= value_in;
         dirty_ff <= dirty_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/settled_slot_journal_writer.sv =====
// top level: slot cell row, journal cursor, record save sequencer and control registers
// result: a word is taken on a req_valid and req_ready handshake and its result sits in the output register next cycle
// throughput: one word per cycle while rsp_ready is high; the state update, the
// priority pick down the slot cell chain and the cursor compare all complete in that cycle
// reset: synchronous, active high; slots return to the default table, clean, counters at 64,
// cursor at the sector base, save sequencer idle, control registers to their reset values
module settled_slot_journal_writer #(
   parameter int NUM_SLOTS      = 32,
   parameter int SLOTS_PER_KNOB = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // item channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_opcode,
   input  logic [ssjw_pkg::PAGE_W-1:0]     req_page_slot,
   input  logic [ssjw_pkg::WORD_W-1:0]     req_knob_value_0,
   input  logic [ssjw_pkg::WORD_W-1:0]     req_knob_value_1,
   input  logic [ssjw_pkg::WORD_W-1:0]     req_knob_value_2,
   input  logic [ssjw_pkg::WORD_W-1:0]     req_knob_value_3,
   input  logic [ssjw_pkg::REC_SLOT_W-1:0] req_record_slot,
   input  logic [ssjw_pkg::WORD_W-1:0]     req_record_value,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_flash_action,
   output logic [ssjw_pkg::WORD_W-1:0]     rsp_flash_address,
   output logic [ssjw_pkg::WORD_W-1:0]     rsp_flash_data,
   output logic                            rsp_save_busy,
   // control register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssjw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssjw_pkg::WORD_W-1:0]     csr_wdata
);
   import ssjw_pkg::*;

   // control registers
   logic [WORD_W-1:0] sector_base_ff, sector_end_ff;
   logic [HALF_W-1:0] record_magic_ff, settle_ff;

   // journal and sequencer state
   logic [WORD_W-1:0]    cursor_ff, cursor_in;
   logic [WORD_W-1:0]    block_count_ff, block_count_in;
   logic [WORD_W-1:0]    last_tick_ff, last_tick_in;
   phase_type            phase_ff, phase_in;
   logic [SLOT_ID_W-1:0] pend_slot_ff, pend_slot_in;
   logic [WORD_W-1:0]    pend_addr_ff, pend_addr_in;
   logic [WORD_W-1:0]    pend_id_ff, pend_id_in;
   logic [WORD_W-1:0]    pend_value_ff, pend_value_in;

   // result register
   logic              rsp_valid_ff;
   logic [1:0]        action_ff, action_in;
   logic [WORD_W-1:0] address_ff, address_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              busy_ff, busy_in;

   logic              accept;
   logic              sector_full;
   logic              replay_ok;
   logic              start_record;
   logic              do_erase;
   cmd_type           cmd;
   pick_type          chain [NUM_SLOTS+1];
   logic [NUM_SLOTS-1:0] dirty_vec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // row of slot cells, pick handed from lower to higher slot ids
   assign chain[0] = '0;
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
      localparam int KNOB = i / SLOTS_PER_KNOB;
      logic [WORD_W-1:0] knob_word;
      if (KNOB == 0) begin : g_k0
         assign knob_word = req_knob_value_0;
      end else if (KNOB == 1) begin : g_k1
         assign knob_word = req_knob_value_1;
      end else if (KNOB == 2) begin : g_k2
         assign knob_word = req_knob_value_2;
      end else if (KNOB == 3) begin : g_k3
         assign knob_word = req_knob_value_3;
      end else begin : g_kx
         assign knob_word = '0;
      end
      ssjw_slot_cell #(
         .SLOT_ID       (i),
         .SLOTS_PER_KNOB(SLOTS_PER_KNOB),
         .KNOB_EN       (KNOB < NUM_KNOBS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .knob_value(knob_word),
         .pick_in   (chain[i]),
         .pick_out  (chain[i+1]),
         .dirty     (dirty_vec[i])
      );
   end

   // record would run past the sector end
   assign sector_full = ({1'b0, cursor_ff} + {1'b0, RECORD_BYTES}) > {1'b0, sector_end_ff};
   assign replay_ok   = (9'(req_record_slot) < 9'(NUM_SLOTS));

   // item decode and sequencer next state
   always_comb begin
      cursor_in      = cursor_ff;
      block_count_in = block_count_ff;
      last_tick_in   = last_tick_ff;
      phase_in       = phase_ff;
      pend_slot_in   = pend_slot_ff;
      pend_addr_in   = pend_addr_ff;
      pend_id_in     = pend_id_ff;
      pend_value_in  = pend_value_ff;
      action_in      = ACT_NONE;
      address_in     = '0;
      data_in        = '0;
      start_record   = 1'b0;
      do_erase       = 1'b0;
      cmd              = '0;
      cmd.page_slot    = req_page_slot;
      cmd.clear_slot   = pend_slot_ff;
      cmd.replay_slot  = SLOT_ID_W'(req_record_slot);
      cmd.replay_value = req_record_value;
      cmd.settle       = settle_ff;
      if (accept) begin
         unique case (req_opcode)
            OP_UPDATE: begin
               cmd.update     = 1'b1;
               block_count_in = block_count_ff + 32'd1;
            end
            OP_POLL: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     if (chain[NUM_SLOTS].found && sector_full) begin
                        do_erase  = 1'b1;
                        cmd.erase = 1'b1;
                        cursor_in = sector_base_ff;
                        action_in = ACT_ERASE;
                     end else if (chain[NUM_SLOTS].found) begin
                        start_record  = 1'b1;
                        pend_slot_in  = chain[NUM_SLOTS].slot;
                        pend_addr_in  = cursor_ff;
                        pend_id_in    = {HALF_W'(chain[NUM_SLOTS].slot), record_magic_ff};
                        pend_value_in = chain[NUM_SLOTS].value;
                        cursor_in     = cursor_ff + RECORD_BYTES;
                        phase_in      = PH_ID;
                        last_tick_in  = block_count_ff;
                     end
                  end
                  PH_ID: begin
                     if (block_count_ff != last_tick_ff) begin
                        last_tick_in = block_count_ff;
                        phase_in     = PH_VALUE;
                        action_in    = ACT_PROGRAM;
                        address_in   = pend_addr_ff;
                        data_in      = pend_id_ff;
                     end
                  end
                  PH_VALUE: begin
                     if (block_count_ff != last_tick_ff) begin
                        last_tick_in = block_count_ff;
                        cmd.clear    = 1'b1;
                        phase_in     = PH_IDLE;
                        action_in    = ACT_PROGRAM;
                        address_in   = pend_addr_ff + VALUE_OFFSET;
                        data_in      = pend_value_ff;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            OP_REPLAY: begin
               if (replay_ok) begin
                  cmd.replay = 1'b1;
                  cursor_in  = cursor_ff + RECORD_BYTES;
               end
            end
            default: begin
               cursor_in = cursor_ff;
            end
         endcase
      end
      busy_in = (phase_in != PH_IDLE);
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sector_base_ff  <= SECTOR_BASE_RST;
         sector_end_ff   <= SECTOR_END_RST;
         record_magic_ff <= RECORD_MAGIC_RST;
         settle_ff       <= SETTLE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SECTOR_BASE:  sector_base_ff  <= csr_wdata;
            CSR_SECTOR_END:   sector_end_ff   <= csr_wdata;
            CSR_RECORD_MAGIC: record_magic_ff <= csr_wdata[HALF_W-1:0];
            CSR_SETTLE:       settle_ff       <= csr_wdata[HALF_W-1:0];
            default:          settle_ff       <= settle_ff;
         endcase
      end
   end

   // cursor, tick counter and save phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff      <= SECTOR_BASE_RST;
         block_count_ff <= '0;
         phase_ff       <= PH_IDLE;
      end else begin
         cursor_ff      <= cursor_in;
         block_count_ff <= block_count_in;
         phase_ff       <= phase_in;
      end
   end

   // pending record words
   always_ff @(posedge clock) begin
      last_tick_ff  <= last_tick_in;
      pend_slot_ff  <= pend_slot_in;
      pend_addr_ff  <= pend_addr_in;
      pend_id_ff    <= pend_id_in;
      pend_value_ff <= pend_value_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff  <= action_in;
         address_ff <= address_in;
         data_ff    <= data_in;
         busy_ff    <= busy_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flash_action  = action_ff;
   assign rsp_flash_address = address_ff;
   assign rsp_flash_data    = data_ff;
   assign rsp_save_busy     = busy_ff;

`ifndef SYNTH
   // an erase never leaves a record in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (action_ff == ACT_ERASE) |-> !busy_ff)
      else $error("erase reported with a record in flight");

   // a started record moves the cursor by one record
   assert property (@(posedge clock) disable iff (reset)
      start_record |=> cursor_ff == $past(cursor_ff) + RECORD_BYTES)
      else $error("cursor did not advance on record start");

   // after an erase every slot is dirty
   assert property (@(posedge clock) disable iff (reset)
      do_erase |=> &dirty_vec)
      else $error("slot left clean after sector erase");

   // id word programmed on a new tick moves the sequencer to the value word
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_POLL) && (phase_ff == PH_ID)
      && (block_count_ff != last_tick_ff) |=> phase_ff == PH_VALUE)
      else $error("save sequencer missed the value phase");
`endif

endmodule

// ===== tb/ssjw_journal_checker.sv =====
`timescale 1ns / 1ps
// checker for the slot journal writer: watches all channels, predicts flash results and compares
module ssjw_journal_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_page_slot,
   input  logic [31:0] req_knob_value_0,
   input  logic [31:0] req_knob_value_1,
   input  logic [31:0] req_knob_value_2,
   input  logic [31:0] req_knob_value_3,
   input  logic [4:0]  req_record_slot,
   input  logic [31:0] req_record_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_flash_action,
   input  logic [31:0] rsp_flash_address,
   input  logic [31:0] rsp_flash_data,
   input  logic        rsp_save_busy,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          words_pending
);
   import ssjw_pkg::*;

   localparam int SLOT_TOTAL = 32;
   localparam int PAGE_SLOTS = 8;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] address;
      logic [31:0] data;
      logic        busy;
   } flash_result_type;

   // register copy
   logic [31:0] base_addr;
   logic [31:0] end_addr;
   logic [15:0] magic_word;
   logic [15:0] settle_limit;

   // slot table and record sequencer copy
   logic [31:0]   slot_word [SLOT_TOTAL];
   logic          slot_dirty [SLOT_TOTAL];
   logic [15:0]   slot_age [SLOT_TOTAL];
   logic [31:0]   cursor;
   logic [31:0]   block_ticks;
   logic [31:0]   last_tick;
   logic [31:0]   rec_address;
   logic [31:0]   rec_id;
   logic [31:0]   rec_value;
   logic [4:0]    rec_slot;
   phase_type     save_phase;

   flash_result_type expected_results [$];
   int               mismatches = 0;

   // power-up slot words, zero past the table
   function automatic logic [31:0] boot_word(input int idx);
      logic [31:0] w;
      case (idx)
         0:  w = 32'h3ED1EB85;
         1:  w = 32'h3E428F5C;
         2:  w = 32'h3F400000;
         3:  w = 32'h3F5C28F6;
         4:  w = 32'h3F63D70A;
         5:  w = 32'h3F570A3D;
         7:  w = 32'h3E800000;
         8:  w = 32'h3F0CCCCD;
         10: w = 32'h3E8F5C29;
         11: w = 32'h3D75C28F;
         12: w = 32'h3F4F5C29;
         13: w = 32'h3F400000;
         14: w = 32'h3F800000;
         15: w = 32'h3F028F5C;
         16, 17, 18, 20, 22, 28: w = 32'h3F800000;
         24: w = 32'h3F5C28F6;
         25: w = 32'h3EBD70A4;
         26: w = 32'h3F266666;
         27: w = 32'h3E6147AE;
         29: w = 32'h3E947AE1;
         30: w = 32'h3E8A3D71;
         31: w = 32'h3EAE147B;
         default: w = 32'h00000000;
      endcase
      return w;
   endfunction

   task automatic clear_journal_model();
      base_addr    = SECTOR_BASE_RST;
      end_addr     = SECTOR_END_RST;
      magic_word   = RECORD_MAGIC_RST;
      settle_limit = SETTLE_RST;
      for (int i = 0; i < SLOT_TOTAL; i++) begin
         slot_word[i]  = boot_word(i);
         slot_dirty[i] = 1'b0;
         slot_age[i]   = SETTLE_RST;
      end
      cursor      = SECTOR_BASE_RST;
      block_ticks = '0;
      last_tick   = '0;
      rec_address = '0;
      rec_id      = '0;
      rec_value   = '0;
      rec_slot    = '0;
      save_phase  = PH_IDLE;
   endtask

   // advance the slot table by one word and work out its flash result
   task automatic predict_flash(input logic [1:0] op, input logic [2:0] page,
                                input logic [3:0][31:0] knobs, input logic [4:0] rs,
                                input logic [31:0] rv, output flash_result_type res);
      int sid;
      int pick;
      res = '0;
      res.action = ACT_NONE;
      case (op)
         OP_UPDATE: begin
            // changed knob words restart their settle count
            for (int k = 0; k < NUM_KNOBS; k++) begin
               sid = k * PAGE_SLOTS + page;
               if (slot_word[sid] != knobs[k]) begin
                  slot_word[sid]  = knobs[k];
                  slot_dirty[sid] = 1'b1;
                  slot_age[sid]   = '0;
               end
            end
            for (int i = 0; i < SLOT_TOTAL; i++)
               if (slot_dirty[i] && slot_age[i] < settle_limit)
                  slot_age[i] = slot_age[i] + 16'd1;
            block_ticks = block_ticks + 32'd1;
         end
         OP_POLL: begin
            if (save_phase == PH_IDLE) begin
               // lowest settled dirty slot
               pick = -1;
               for (int i = 0; i < SLOT_TOTAL; i++)
                  if (pick < 0 && slot_dirty[i] && slot_age[i] >= settle_limit)
                     pick = i;
               if (pick >= 0) begin
                  if ({1'b0, cursor} + {1'b0, RECORD_BYTES} > {1'b0, end_addr}) begin
                     // sector full: erase and mark everything for rewrite
                     cursor = base_addr;
                     for (int i = 0; i < SLOT_TOTAL; i++) begin
                        slot_dirty[i] = 1'b1;
                        slot_age[i]   = settle_limit;
                     end
                     res.action = ACT_ERASE;
                  end else begin
                     rec_slot    = pick[4:0];
                     rec_address = cursor;
                     rec_id      = {11'd0, pick[4:0], magic_word};
                     rec_value   = slot_word[pick];
                     cursor      = cursor + RECORD_BYTES;
                     save_phase  = PH_ID;
                     last_tick   = block_ticks;
                  end
               end
            end else if (block_ticks != last_tick) begin
               // one record word per block tick
               last_tick = block_ticks;
               res.action = ACT_PROGRAM;
               if (save_phase == PH_ID) begin
                  save_phase  = PH_VALUE;
                  res.address = rec_address;
                  res.data    = rec_id;
               end else begin
                  slot_dirty[rec_slot] = 1'b0;
                  save_phase  = PH_IDLE;
                  res.address = rec_address + VALUE_OFFSET;
                  res.data    = rec_value;
               end
            end
         end
         OP_REPLAY: begin
            slot_word[rs] = rv;
            cursor = cursor + RECORD_BYTES;
         end
         default: ;
      endcase
      res.busy = (save_phase != PH_IDLE);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   // track accepted words on all three channels
   always @(posedge clock) begin : watch_channels
      flash_result_type want;
      flash_result_type next_word;
      if (reset) begin
         clear_journal_model();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected, expected none, actual %h %h %h %b",
                        $time, rsp_flash_action, rsp_flash_address, rsp_flash_data,
                        rsp_save_busy);
            end else begin
               want = expected_results.pop_front();
               check_field("flash_action", {30'd0, want.action}, {30'd0, rsp_flash_action});
               check_field("flash_address", want.address, rsp_flash_address);
               check_field("flash_data", want.data, rsp_flash_data);
               check_field("save_busy", {31'd0, want.busy}, {31'd0, rsp_save_busy});
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SECTOR_BASE:  base_addr = csr_wdata;
               CSR_SECTOR_END:   end_addr = csr_wdata;
               CSR_RECORD_MAGIC: magic_word = csr_wdata[15:0];
               CSR_SETTLE:       settle_limit = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_flash(req_opcode, req_page_slot,
                          {req_knob_value_3, req_knob_value_2, req_knob_value_1,
                           req_knob_value_0},
                          req_record_slot, req_record_value, next_word);
            expected_results.push_back(next_word);
         end
      end
      fail_count    <= mismatches;
      words_pending <= expected_results.size();
   end

endmodule

// ===== tb/tb_settled_slot_journal_writer.sv =====
`timescale 1ns / 1ps
// testbench top for the slot journal writer: clock, reset, stimulus and verdict
module tb_settled_slot_journal_writer;
   import ssjw_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         STALL_SPAN  = 300;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [2:0]       page;
      logic [3:0][31:0] knobs;
      logic [4:0]       rec_slot;
      logic [31:0]      rec_value;
   } journal_cmd_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [2:0]  req_page_slot;
   logic [31:0] req_knob_value_0;
   logic [31:0] req_knob_value_1;
   logic [31:0] req_knob_value_2;
   logic [31:0] req_knob_value_3;
   logic [4:0]  req_record_slot;
   logic [31:0] req_record_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_flash_action;
   logic [31:0] rsp_flash_address;
   logic [31:0] rsp_flash_data;
   logic        rsp_save_busy;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int          fail_count;
   int          words_pending;
   int          cycle_count = 0;
   int          items_sent = 0;
   int          send_idle = 32;
   int          recv_idle = 67;
   int          stall_asks = 0;
   int          stalls_served = 0;
   logic [31:0] word_pool [4];
   logic [31:0] sector_pick;

   settled_slot_journal_writer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_page_slot     (req_page_slot),
      .req_knob_value_0  (req_knob_value_0),
      .req_knob_value_1  (req_knob_value_1),
      .req_knob_value_2  (req_knob_value_2),
      .req_knob_value_3  (req_knob_value_3),
      .req_record_slot   (req_record_slot),
      .req_record_value  (req_record_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flash_action  (rsp_flash_action),
      .rsp_flash_address (rsp_flash_address),
      .rsp_flash_data    (rsp_flash_data),
      .rsp_save_busy     (rsp_save_busy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   ssjw_journal_checker journal_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_page_slot     (req_page_slot),
      .req_knob_value_0  (req_knob_value_0),
      .req_knob_value_1  (req_knob_value_1),
      .req_knob_value_2  (req_knob_value_2),
      .req_knob_value_3  (req_knob_value_3),
      .req_record_slot   (req_record_slot),
      .req_record_value  (req_record_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flash_action  (rsp_flash_action),
      .rsp_flash_address (rsp_flash_address),
      .rsp_flash_data    (rsp_flash_data),
      .rsp_save_busy     (rsp_save_busy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .words_pending     (words_pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random back-pressure, or a long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_asks > stalls_served) begin
            stalls_served++;
            rsp_ready <= 1'b0;
            repeat (STALL_SPAN) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   function automatic journal_cmd_type shape(input logic [1:0] op, input logic [2:0] page,
                                             input logic [31:0] k0, input logic [31:0] k1,
                                             input logic [31:0] k2, input logic [31:0] k3,
                                             input logic [4:0] rs, input logic [31:0] rv);
      journal_cmd_type c;
      c.opcode    = op;
      c.page      = page;
      c.knobs[0]  = k0;
      c.knobs[1]  = k1;
      c.knobs[2]  = k2;
      c.knobs[3]  = k3;
      c.rec_slot  = rs;
      c.rec_value = rv;
      return c;
   endfunction

   // mostly recurring words so slots often stay unchanged and settle
   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return word_pool[2'($urandom_range(0, 3))];
      return $urandom;
   endfunction

   function automatic journal_cmd_type random_cmd();
      int          r;
      logic [1:0]  op;
      r = $urandom_range(0, 99);
      if (r < 45)
         op = OP_UPDATE;
      else if (r < 85)
         op = OP_POLL;
      else if (r < 97)
         op = OP_REPLAY;
      else
         op = OP_UNUSED;
      return shape(op, 3'($urandom_range(0, 7)), pick_word(), pick_word(), pick_word(),
                   pick_word(), 5'($urandom_range(0, 31)), pick_word());
   endfunction

   // offer one word and hold it until taken; valid stays up for a following word
   task automatic send(input journal_cmd_type c);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= c.opcode;
      req_page_slot    <= c.page;
      req_knob_value_0 <= c.knobs[0];
      req_knob_value_1 <= c.knobs[1];
      req_knob_value_2 <= c.knobs[2];
      req_knob_value_3 <= c.knobs[3];
      req_record_slot  <= c.rec_slot;
      req_record_value <= c.rec_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (items_sent == 200 || items_sent == 1100)
         stall_asks++;
      // idle schedule: sender light / receiver heavy, then swapped, then none
      if (items_sent < 435) begin
         send_idle = 32;
         recv_idle = 67;
      end else if (items_sent < 870) begin
         send_idle = 67;
         recv_idle = 32;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   // stop offering and wait for every predicted result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // register writes only with the block idle
   task automatic configure(input logic [31:0] base, input logic [31:0] limit,
                            input logic [31:0] magic, input logic [31:0] settle);
      drain();
      set_reg(CSR_SECTOR_BASE, base);
      set_reg(CSR_SECTOR_END, limit);
      set_reg(CSR_RECORD_MAGIC, magic);
      set_reg(CSR_SETTLE, settle);
      csr_valid <= 1'b0;
   endtask

   task automatic run_burst(input int n);
      word_pool[0] = 32'h0000_0000;
      word_pool[1] = 32'hFFFF_FFFF;
      word_pool[2] = $urandom;
      word_pool[3] = $urandom;
      for (int i = 0; i < n; i++) begin
         send(random_cmd());
         if (i == n / 2)
            drain();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_UPDATE;
      req_page_slot    = '0;
      req_knob_value_0 = '0;
      req_knob_value_1 = '0;
      req_knob_value_2 = '0;
      req_knob_value_3 = '0;
      req_record_slot  = '0;
      req_record_value = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_SECTOR_BASE;
      csr_wdata        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: sector at the top of the address space, fast settle
      configure(32'hFFFF_FFE8, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd1);
      // nothing dirty yet
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_UNUSED, 7, '1, '1, '1, '1, 31, '1));
      send(shape(OP_UPDATE, 0, '1, '1, '1, '1, 0, 0));
      send(shape(OP_UPDATE, 7, 0, 0, 0, 0, 0, 0));
      // record start, then a poll in the same tick
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      // replay while a record is in flight
      send(shape(OP_REPLAY, 0, 0, 0, 0, 0, 31, '1));
      send(shape(OP_UPDATE, 3, 0, 0, 0, 0, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_UPDATE, 3, 0, 0, 0, 0, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      // cursor runs past the sector end: erase
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      // replays walk the cursor across the 32-bit wrap
      send(shape(OP_REPLAY, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_REPLAY, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_REPLAY, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_UPDATE, 5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_UPDATE, 5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 0, 0));
      send(shape(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send(shape(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));

      // power-up register values
      configure(SECTOR_BASE_RST, SECTOR_END_RST, RECORD_MAGIC_RST, SETTLE_RST);
      run_burst(120);

      // small sectors with quick settling, erase comes often
      for (int p = 0; p < 6; p++) begin
         sector_pick = $urandom;
         configure(sector_pick, sector_pick + RECORD_BYTES * $urandom_range(2, 12), $urandom,
                   $urandom_range(1, 4));
         run_burst(110);
      end

      // zero sector and zero settle limit
      configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
      run_burst(90);

      // top of address space, longest settle
      configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
      run_burst(90);

      // sector end below its base
      configure(32'h0000_1000, 32'h0000_0800, 32'h0000_0001, 32'd2);
      run_burst(80);

      // roomier sectors
      for (int p = 0; p < 3; p++) begin
         sector_pick = $urandom & 32'hFFFF_FFF8;
         configure(sector_pick, sector_pick + RECORD_BYTES * $urandom_range(20, 60),
                   $urandom, $urandom_range(1, 8));
         run_burst(90);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
